>>> sv/bss_pkg.sv
// types and constants shared by the bassline step sequencer
package bss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DIV_CNT_W  = 8;
  localparam int unsigned HALF_DEPTH = 128;
  localparam int unsigned HALF_AW    = 7;

  localparam logic [6:0] BASE_NOTE   = 7'd60;
  localparam logic [6:0] OCTAVE      = 7'd12;
  localparam logic [6:0] TWO_OCTAVES = 7'd24;
  localparam logic [2:0] PHASES      = 3'd6;
  localparam logic [2:0] PHASE_STEP  = 3'd0;
  localparam logic [2:0] PHASE_OFF   = 3'd4;
  localparam logic [7:0] PAR_OFFSET  = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WTO_ENABLE      = 3'd0,
    REG_ARP_ENABLE      = 3'd1,
    REG_PATTERN_SELECT  = 3'd2,
    REG_STEP_LENGTH     = 3'd3,
    REG_CLOCK_DIVIDER   = 3'd4,
    REG_SYNC_TO_MEASURE = 3'd5,
    REG_PARAM_ASSIGN    = 3'd6,
    REG_CHANNEL_SELECT  = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    GATE_NONE   = 2'd0,
    GATE_SET    = 2'd1,
    GATE_CLEAR  = 2'd2,
    GATE_CANCEL = 2'd3
  } gate_act_e;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_OFF   = 2'd2
  } step_kind_e;

  typedef enum logic [1:0] {
    OCT_NONE = 2'd0,
    OCT_UP   = 2'd1,
    OCT_DOWN = 2'd2,
    OCT_UP2  = 2'd3
  } oct_e;

  typedef struct packed {
    step_kind_e kind;
    gate_act_e  act;
    logic       slide_clr;
    logic       gate;
    logic       voice;
    logic [7:0] pos;
  } stage_ctrl_t;

endpackage

>>> sv/bassline_step_sequencer.sv
// bassline step sequencer top level: clock division, step position and step decode
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid_i / in_ready_o, item fields  | in
//  result   | out_valid_o / out_ready_i, fields     | out
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i       | in
//
// one beat in per cycle while in_ready_o is high; the front stage updates
// counters and position and reads the two step memory halves; the decode stage
// turns the step bytes into the result register
// reset clears all control state; the step memory holds no reset value
// a stalled result holds the middle stage, which then holds off new beats
module bassline_step_sequencer
  import bss_pkg::*;
#(
  parameter int unsigned DIV_WIDTH = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic                  clk_pulse_i,
  input  logic                  midi_start_i,
  input  logic                  midi_continue_i,
  input  logic                  midi_stop_i,
  input  logic                  restart_request_i,
  input  logic                  gate_active_i,
  input  logic [7:0]            mem_address_i,
  input  logic [7:0]            mem_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            gate_action_o,
  output logic [6:0]            note_o,
  output logic                  accent_o,
  output logic                  porta_active_o,
  output logic                  voice_active_o,
  output logic                  step_played_o,
  output logic                  par_write_o,
  output logic [7:0]            par_value_o,
  output logic [7:0]            position_o
);

  // configuration
  logic                 wto_q, arp_q, sync_q;
  logic [3:0]           pat_q, len_q;
  logic [DIV_WIDTH-1:0] cdiv_q;
  logic [7:0]           passign_q;

  // front stage state
  logic                 seq_en_q, seq_en_d;
  logic [DIV_CNT_W-1:0] div_q, div_d;
  logic [2:0]           sub_q, sub_d;
  logic [7:0]           pos_q, pos_d;
  logic                 voice_q, voice_d;

  // middle stage
  logic        a_valid_q;
  stage_ctrl_t a_q, a_d;
  logic        a_advance, in_accept;

  // decode stage state
  logic       slide_q, slide_d;
  logic       accent_q, accent_d;
  logic       porta_q, porta_d;
  logic [6:0] note_q, note_d;

  // result register
  logic       out_valid_q;
  gate_act_e  r_act_q, r_act_d;
  logic       r_played_q, r_played_d;
  logic       r_pw_q, r_pw_d;
  logic [7:0] r_pv_q, r_pv_d;

  logic [7:0] note_byte, par_byte;
  logic       mem_we, mem_re;

  assign in_accept  = in_valid_i && in_ready_o;
  assign a_advance  = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wto_q     <= 1'b0;
      arp_q     <= 1'b0;
      pat_q     <= 4'd0;
      len_q     <= 4'd15;
      cdiv_q    <= '0;
      sync_q    <= 1'b0;
      passign_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WTO_ENABLE:      wto_q     <= cfg_data_i[0];
        REG_ARP_ENABLE:      arp_q     <= cfg_data_i[0];
        REG_PATTERN_SELECT:  pat_q     <= cfg_data_i[3:0];
        REG_STEP_LENGTH:     len_q     <= cfg_data_i[3:0];
        REG_CLOCK_DIVIDER:   cdiv_q    <= cfg_data_i[DIV_WIDTH-1:0];
        REG_SYNC_TO_MEASURE: sync_q    <= cfg_data_i[0];
        REG_PARAM_ASSIGN:    passign_q <= cfg_data_i;
        // side routing only, nothing here depends on it
        REG_CHANNEL_SELECT:  ;
        default:             ;
      endcase
    end
  end

  // front stage: events, clock division, position
  always_comb begin
    logic                 restart;
    logic [DIV_CNT_W-1:0] div_inc;
    logic [2:0]           sub_inc;
    logic [4:0]           nstep;
    logic [3:0]           nstep_w;
    logic [3:0]           npat;

    restart = !seq_en_q || midi_start_i || restart_request_i;
    div_inc = '0;
    sub_inc = '0;
    nstep   = '0;
    nstep_w = '0;
    npat    = '0;

    seq_en_d = seq_en_q;
    div_d    = div_q;
    sub_d    = sub_q;
    pos_d    = pos_q;
    voice_d  = voice_q;

    a_d.kind      = KIND_IDLE;
    a_d.act       = GATE_NONE;
    a_d.slide_clr = 1'b0;
    a_d.gate      = gate_active_i;

    if (op_e'(operation_i) == OP_TICK) begin
      if (midi_stop_i) begin
        voice_d = 1'b0;
        a_d.act = GATE_CLEAR;
      end else if (!wto_q) begin
        if (seq_en_q) begin
          a_d.act = GATE_CLEAR;
        end
        seq_en_d = 1'b0;
      end else if (!arp_q) begin
        if (restart) begin
          div_d         = '1;
          sub_d         = '1;
          pos_d         = {1'b0, pat_q[2:0], 4'd0} - 8'd1;
          a_d.slide_clr = 1'b1;
        end
        if (midi_start_i || midi_continue_i) begin
          voice_d = 1'b1;
        end
        seq_en_d = 1'b1;
        if (clk_pulse_i) begin
          div_inc = div_d + 1'b1;
          if (div_inc == '0 || div_inc > DIV_CNT_W'(cdiv_q)) begin
            div_d   = '0;
            sub_inc = sub_d + 3'd1;
            sub_d   = (sub_inc >= PHASES) ? PHASE_STEP : sub_inc;
            if (sub_d == PHASE_STEP) begin
              nstep   = {1'b0, pos_d[3:0]} + 5'd1;
              nstep_w = (nstep > {1'b0, len_q}) ? 4'd0 : nstep[3:0];
              npat    = pos_d[7:4];
              if (!sync_q || nstep_w == 4'd0) begin
                npat = {1'b0, pat_q[2:0]};
              end
              pos_d = {npat, nstep_w};
              if (pat_q[3]) begin
                if (gate_active_i) begin
                  a_d.act = GATE_CLEAR;
                end
              end else begin
                a_d.kind = KIND_FETCH;
              end
            end else if (sub_d == PHASE_OFF) begin
              a_d.kind = KIND_OFF;
            end
          end else begin
            div_d = div_inc;
          end
        end
      end
    end

    a_d.voice = voice_d;
    a_d.pos   = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_en_q  <= 1'b0;
      div_q     <= '1;
      sub_q     <= '1;
      pos_q     <= '1;
      voice_q   <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        seq_en_q  <= seq_en_d;
        div_q     <= div_d;
        sub_q     <= sub_d;
        pos_q     <= pos_d;
        voice_q   <= voice_d;
        a_valid_q <= 1'b1;
      end else if (a_advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= a_d;
    end
  end

  // step memory, split into note and parameter halves by address bit 7
  assign mem_we = in_accept && (op_e'(operation_i) == OP_WRITE);
  assign mem_re = in_accept && (a_d.kind == KIND_FETCH);

  bss_ram #(
    .WIDTH (8),
    .DEPTH (HALF_DEPTH)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we && !mem_address_i[7]),
    .waddr_i (mem_address_i[HALF_AW-1:0]),
    .wdata_i (mem_data_i),
    .re_i    (mem_re),
    .raddr_i (pos_d[HALF_AW-1:0]),
    .rdata_o (note_byte)
  );

  bss_ram #(
    .WIDTH (8),
    .DEPTH (HALF_DEPTH)
  ) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we && mem_address_i[7]),
    .waddr_i (mem_address_i[HALF_AW-1:0]),
    .wdata_i (mem_data_i),
    .re_i    (mem_re),
    .raddr_i (pos_d[HALF_AW-1:0]),
    .rdata_o (par_byte)
  );

  // decode stage: step bytes into note, accent, slide, gate and parameter requests
  always_comb begin
    logic       slide_eff;
    logic [6:0] n;

    slide_eff = a_q.slide_clr ? 1'b0 : slide_q;
    n         = {3'd0, note_byte[3:0]} + BASE_NOTE;

    slide_d    = slide_eff;
    accent_d   = accent_q;
    porta_d    = porta_q;
    note_d     = note_q;
    r_act_d    = a_q.act;
    r_played_d = 1'b0;
    r_pw_d     = 1'b0;
    r_pv_d     = 8'd0;

    case (a_q.kind)
      KIND_FETCH: begin
        case (oct_e'(note_byte[5:4]))
          OCT_UP:   n = n + OCTAVE;
          OCT_DOWN: n = n - OCTAVE;
          OCT_UP2:  n = n + TWO_OCTAVES;
          default:  ;
        endcase
        note_d = n;
        if (!slide_eff) begin
          accent_d = par_byte[7];
        end
        porta_d    = slide_eff;
        slide_d    = note_byte[6];
        r_act_d    = GATE_NONE;
        if (note_byte[7] && a_q.voice) begin
          r_act_d = a_q.gate ? GATE_CANCEL : GATE_SET;
        end
        if (passign_q != 8'd0) begin
          r_pw_d = 1'b1;
          r_pv_d = {1'b0, par_byte[6:0]} + PAR_OFFSET;
        end
        r_played_d = 1'b1;
      end
      KIND_OFF: begin
        r_act_d = slide_eff ? GATE_NONE : GATE_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slide_q     <= 1'b0;
      accent_q    <= 1'b0;
      porta_q     <= 1'b0;
      note_q      <= BASE_NOTE;
      out_valid_q <= 1'b0;
    end else begin
      if (a_advance) begin
        slide_q     <= slide_d;
        accent_q    <= accent_d;
        porta_q     <= porta_d;
        note_q      <= note_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_advance) begin
      r_act_q    <= r_act_d;
      r_played_q <= r_played_d;
      r_pw_q     <= r_pw_d;
      r_pv_q     <= r_pv_d;
      voice_active_o <= a_q.voice;
      position_o     <= a_q.pos;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gate_action_o  = r_act_q;
  assign note_o         = note_q;
  assign accent_o       = accent_q;
  assign porta_active_o = porta_q;
  assign step_played_o  = r_played_q;
  assign par_write_o    = r_pw_q;
  assign par_value_o    = r_pv_q;

`ifndef ASSERT_OFF
  // a fetched step never closes the gate
  a_fetch_no_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_played_o |-> gate_action_o != GATE_CLEAR)
    else $error("step fetch issued a gate clear");

  // parameter value stays zero without a parameter write
  a_par_value_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !par_write_o |-> par_value_o == 8'd0)
    else $error("parameter value without parameter write");

  // the subcounter never reaches six; all ones only follows reset or a restart
  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 3'd6)
    else $error("subcounter left its six phases");

  // an empty result register never holds off an input beat
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with result register empty");

  // a held middle stage keeps its content
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_advance |=> a_valid_q && $stable(a_q))
    else $error("middle stage changed while stalled");
`endif

endmodule

>>> sv/bss_ram.sv
// generic single write port ram with registered read
module bss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/tb_bassline_step_sequencer.sv
// self-checking bassline step sequencer testbench: directed and random beats vs a predictor
`timescale 1ns / 100ps

module tb_bassline_step_sequencer;
  import bss_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 150;

  typedef struct packed {
    op_e        op;
    logic       clk;
    logic       start;
    logic       cont;
    logic       stop;
    logic       restart;
    logic       gate;
    logic [7:0] addr;
    logic [7:0] data;
  } seq_beat_t;

  typedef struct packed {
    gate_act_e  act;
    logic [6:0] note;
    logic       accent;
    logic       porta;
    logic       voice;
    logic       played;
    logic       pw;
    logic [7:0] pv;
    logic [7:0] pos;
  } seq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic result_ready = 1'b0;
  seq_beat_t cur_beat = '0;

  logic in_ready_o, out_valid_o;
  logic [1:0] gate_action_o;
  logic [6:0] note_o;
  logic accent_o, porta_active_o, voice_active_o, step_played_o, par_write_o;
  logic [7:0] par_value_o, position_o;

  // predictor copy of the registers
  logic       mode_on, arp_on, sync_measure;
  logic [3:0] pattern_sel, last_step;
  logic [5:0] divider;
  logic [7:0] par_target;

  // predictor copy of the sequencer state
  logic       seq_on, voice_on, slide, accent, porta;
  logic [7:0] div_cnt, step_pos;
  logic [2:0] sub_cnt;
  logic [6:0] note_now;
  logic [7:0] step_mem [256];

  seq_beat_t   beats_to_send [$];
  seq_result_t step_results [$];
  int outstanding = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  int rx_mode = 0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  bassline_step_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .operation_i      (cur_beat.op),
    .clk_pulse_i      (cur_beat.clk),
    .midi_start_i     (cur_beat.start),
    .midi_continue_i  (cur_beat.cont),
    .midi_stop_i      (cur_beat.stop),
    .restart_request_i(cur_beat.restart),
    .gate_active_i    (cur_beat.gate),
    .mem_address_i    (cur_beat.addr),
    .mem_data_i       (cur_beat.data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (result_ready),
    .gate_action_o    (gate_action_o),
    .note_o           (note_o),
    .accent_o         (accent_o),
    .porta_active_o   (porta_active_o),
    .voice_active_o   (voice_active_o),
    .step_played_o    (step_played_o),
    .par_write_o      (par_write_o),
    .par_value_o      (par_value_o),
    .position_o       (position_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic seq_result_t advance_sequencer(seq_beat_t b);
    seq_result_t r;
    logic [4:0] nstep;
    logic [3:0] npat;
    logic [7:0] nb, ab;
    logic [6:0] n;
    r = '0;
    if (b.op == OP_WRITE) begin
      step_mem[b.addr] = b.data;
    end else if (b.stop) begin
      voice_on = 1'b0;
      r.act = GATE_CLEAR;
    end else if (!mode_on) begin
      if (seq_on) r.act = GATE_CLEAR;
      seq_on = 1'b0;
    end else if (!arp_on) begin
      if (!seq_on || b.start || b.restart) begin
        div_cnt = 8'hff;
        sub_cnt = 3'd7;
        step_pos = {1'b0, pattern_sel[2:0], 4'h0} - 8'd1;
        slide = 1'b0;
      end
      if (b.start || b.cont) voice_on = 1'b1;
      seq_on = 1'b1;
      if (b.clk) begin
        div_cnt = div_cnt + 8'd1;
        if (div_cnt == 8'd0 || div_cnt > {2'b00, divider}) begin
          div_cnt = 8'd0;
          sub_cnt = sub_cnt + 3'd1;
          if (sub_cnt >= PHASES) sub_cnt = 3'd0;
          if (sub_cnt == PHASE_STEP) begin
            nstep = {1'b0, step_pos[3:0]} + 5'd1;
            npat = step_pos[7:4];
            if (nstep > {1'b0, last_step}) nstep = 5'd0;
            if (!sync_measure || nstep == 5'd0) npat = {1'b0, pattern_sel[2:0]};
            step_pos = {npat, nstep[3:0]};
            if (pattern_sel[3]) begin
              if (b.gate) r.act = GATE_CLEAR;
            end else begin
              nb = step_mem[{1'b0, step_pos[6:0]}];
              ab = step_mem[{1'b1, step_pos[6:0]}];
              n = {3'b000, nb[3:0]} + BASE_NOTE;
              case (oct_e'(nb[5:4]))
                OCT_UP:   n = n + OCTAVE;
                OCT_DOWN: n = n - OCTAVE;
                OCT_UP2:  n = n + TWO_OCTAVES;
                default:  ;
              endcase
              note_now = n;
              if (!slide) accent = ab[7];
              porta = slide;
              slide = nb[6];
              if (nb[7] && voice_on) r.act = b.gate ? GATE_CANCEL : GATE_SET;
              if (par_target != 8'd0) begin
                r.pw = 1'b1;
                r.pv = {1'b1, ab[6:0]};
              end
              r.played = 1'b1;
            end
          end else if (sub_cnt == PHASE_OFF) begin
            if (!slide) r.act = GATE_CLEAR;
          end
        end
      end
    end
    r.note = note_now;
    r.accent = accent;
    r.porta = porta;
    r.voice = voice_on;
    r.pos = step_pos;
    return r;
  endfunction

  function automatic string fmt_result(seq_result_t r);
    return $sformatf({"act %0d note %0d acc %0b porta %0b voice %0b fetch %0b",
                      " pw %0b pv %02h pos %02h"},
                     r.act, r.note, r.accent, r.porta, r.voice, r.played, r.pw, r.pv, r.pos);
  endfunction

  function automatic seq_beat_t tick_beat(logic clk, logic st, logic co, logic sp, logic rs,
                                          logic gt);
    seq_beat_t b;
    b = '0;
    b.op = OP_TICK;
    b.clk = clk;
    b.start = st;
    b.cont = co;
    b.stop = sp;
    b.restart = rs;
    b.gate = gt;
    b.addr = 8'($urandom);
    b.data = 8'($urandom);
    return b;
  endfunction

  task automatic queue_beat(seq_beat_t b);
    beats_to_send.push_back(b);
    outstanding++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_WTO_ENABLE:      mode_on = val[0];
      REG_ARP_ENABLE:      arp_on = val[0];
      REG_PATTERN_SELECT:  pattern_sel = val[3:0];
      REG_STEP_LENGTH:     last_step = val[3:0];
      REG_CLOCK_DIVIDER:   divider = val[5:0];
      REG_SYNC_TO_MEASURE: sync_measure = val[0];
      REG_PARAM_ASSIGN:    par_target = val;
      // side routing only, no effect on results
      REG_CHANNEL_SELECT:  ;
      default:             ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic wto, logic arp, logic [3:0] pat, logic [3:0] len,
                            logic [5:0] div, logic sync, logic [7:0] par, logic chan);
    write_reg(REG_WTO_ENABLE, {7'd0, wto});
    write_reg(REG_ARP_ENABLE, {7'd0, arp});
    write_reg(REG_PATTERN_SELECT, {4'd0, pat});
    write_reg(REG_STEP_LENGTH, {4'd0, len});
    write_reg(REG_CLOCK_DIVIDER, {2'd0, div});
    write_reg(REG_SYNC_TO_MEASURE, {7'd0, sync});
    write_reg(REG_PARAM_ASSIGN, par);
    write_reg(REG_CHANNEL_SELECT, {7'd0, chan});
  endtask

  // sender: bursts of beats, with or without a gap between them
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (beats_to_send.size() != 0) begin
        cur_beat <= beats_to_send.pop_front();
        burst_left--;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left = SQUEEZE_CYCLES;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (rx_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 3) != 0);
        default: result_ready <= (mode_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    seq_result_t got, want;
    if (rst_ni) begin
      in_took = in_valid && in_ready_o;
      out_took = out_valid_o && result_ready;
      if (in_took || out_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_took) begin
        got = seq_result_t'({gate_action_o, note_o, accent_o, porta_active_o, voice_active_o,
                             step_played_o, par_write_o, par_value_o, position_o});
        if (step_results.size() == 0) begin
          if (mismatches < 10) $display("result beat with nothing expected: %s", fmt_result(got));
          mismatches++;
        end else begin
          want = step_results.pop_front();
          outstanding--;
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("step result mismatch\n  want %s\n  got  %s",
                       fmt_result(want), fmt_result(got));
            end
            mismatches++;
          end
        end
      end
      if (in_took) step_results.push_back(advance_sequencer(cur_beat));
    end
  end

  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb_bassline_step_sequencer NOT OK");
    $finish;
  end

  initial begin
    seq_beat_t b;
    mode_on = 1'b0;
    arp_on = 1'b0;
    pattern_sel = 4'd0;
    last_step = 4'd15;
    divider = 6'd0;
    sync_measure = 1'b0;
    par_target = 8'd0;
    seq_on = 1'b0;
    div_cnt = 8'hff;
    sub_cnt = 3'd7;
    step_pos = 8'hff;
    voice_on = 1'b0;
    slide = 1'b0;
    accent = 1'b0;
    porta = 1'b0;
    note_now = BASE_NOTE;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the whole step memory before any fetch
    for (int i = 0; i < 256; i++) begin
      b = tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      b.op = OP_WRITE;
      b.addr = i[7:0];
      b.data = 8'($urandom);
      queue_beat(b);
    end
    wait_drained();

    set_config(1'b1, 1'b0, 4'd0, 4'd15, 6'd0, 1'b0, 8'hff, 1'b0);
    queue_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_beat(tick_beat(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < 6; i++) queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, i[0]));
    queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    queue_beat(tick_beat(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    b = tick_beat(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    b.op = OP_WRITE;
    b.addr = 8'h00;
    b.data = 8'hff;
    queue_beat(b);
    b = tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    b.op = OP_WRITE;
    b.addr = 8'hff;
    b.data = 8'h00;
    queue_beat(b);
    queue_beat(tick_beat(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    wait_drained();

    // mode off clears the gate once
    write_reg(REG_WTO_ENABLE, 8'd0);
    queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    wait_drained();

    // stop pattern with the gate open and closed
    set_config(1'b1, 1'b0, 4'd12, 4'd15, 6'd0, 1'b0, 8'hff, 1'b0);
    queue_beat(tick_beat(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    for (int i = 0; i < 6; i++) queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    wait_drained();

    write_reg(REG_ARP_ENABLE, 8'd1);
    queue_beat(tick_beat(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       set_config(1'b1, 1'b0, 4'd0, 4'd15, 6'd0, 1'b0, 8'hff, 1'b0);
        1:       set_config(1'b1, 1'b0, 4'd7, 4'd0, 6'd63, 1'b1, 8'd1, 1'b1);
        2:       set_config(1'b1, 1'b0, 4'd3, 4'd7, 6'd1, 1'b1, 8'd0, 1'b1);
        default: set_config($urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0,
                            4'(($urandom_range(0, 3) == 0) ? $urandom_range(8, 15)
                                                           : $urandom_range(0, 7)),
                            4'($urandom_range(0, 15)),
                            6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 2)),
                            1'($urandom_range(0, 1)),
                            8'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255)),
                            1'($urandom_range(0, 1)));
      endcase
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          b = tick_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          b.op = OP_WRITE;
        end else begin
          b = tick_beat($urandom_range(0, 7) != 0, $urandom_range(0, 99) == 0,
                        $urandom_range(0, 59) == 0, $urandom_range(0, 79) == 0,
                        $urandom_range(0, 79) == 0, 1'($urandom_range(0, 1)));
        end
        queue_beat(b);
      end
      if (p == 0) squeeze_req = 1'b1;
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_bassline_step_sequencer OK");
    end else begin
      $display("tb_bassline_step_sequencer NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bss_pkg.sv
sv/bss_ram.sv
sv/bassline_step_sequencer.sv
tb/tb_bassline_step_sequencer.sv
